// File: src/pers_pkg.sv
// Package for the port expander refresh sequencer: payload structs, opcodes,
// sequencer step codes, expander command codes and register indexes.
// No dependencies.
package pers_pkg;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_DEFAULT_DIRECTION = 2'd1;
  localparam logic [1:0] REG_DEFAULT_POLARITY  = 2'd2;
  localparam logic [1:0] REG_DEFAULT_OUTPUT    = 2'd3;

  localparam logic [7:0]  RST_DEVICE_ADDRESS    = 8'h40;
  localparam logic [15:0] RST_DEFAULT_DIRECTION = 16'b1111111110011111;
  localparam logic [15:0] RST_DEFAULT_POLARITY  = 16'b0000000000000000;
  localparam logic [15:0] RST_DEFAULT_OUTPUT    = 16'b0000000001000000;

  // item opcodes
  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_HOST_WRITE = 2'd1;
  localparam logic [1:0] OP_HOST_READ  = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  // sequencer steps
  localparam int PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_INIT  = 3'd0;
  localparam logic [PhaseW-1:0] PH_WDIR  = 3'd1;
  localparam logic [PhaseW-1:0] PH_WPOL  = 3'd2;
  localparam logic [PhaseW-1:0] PH_WOUT  = 3'd3;
  localparam logic [PhaseW-1:0] PH_RADDR = 3'd4;
  localparam logic [PhaseW-1:0] PH_RDATA = 3'd5;

  // shadow select, taken from bits 2..1 of the command code
  localparam logic [1:0] SEL_INPUT     = 2'd0;
  localparam logic [1:0] SEL_OUTPUT    = 2'd1;
  localparam logic [1:0] SEL_POLARITY  = 2'd2;
  localparam logic [1:0] SEL_DIRECTION = 2'd3;

  // expander register commands
  localparam logic [2:0] CMD_INPUT     = 3'd0;
  localparam logic [2:0] CMD_OUTPUT    = 3'd2;
  localparam logic [2:0] CMD_POLARITY  = 3'd4;
  localparam logic [2:0] CMD_DIRECTION = 3'd6;

  localparam logic [2:0] TX_COUNT_WRITE = 3'd4;
  localparam logic [2:0] TX_COUNT_RADDR = 3'd2;
  localparam logic [1:0] RX_COUNT_INPUT = 2'd2;

  // change / sent mark bit positions
  localparam int MARK_DIR = 0;
  localparam int MARK_POL = 1;
  localparam int MARK_OUT = 2;
  localparam logic [2:0] MARKS_ALL = 3'b111;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        bus_busy;
    logic [15:0] received_word;
    logic [2:0]  reg_select;
    logic [15:0] write_word;
  } pers_in_t;

  typedef struct packed {
    logic        start_transfer;
    logic        bus_init;
    logic [2:0]  tx_count;
    logic [1:0]  rx_count;
    logic [7:0]  tx_address_byte;
    logic [2:0]  tx_command;
    logic [15:0] tx_word;
    logic        slot_taken;
    logic [15:0] read_word;
  } pers_out_t;

endpackage

// File: src/port_expander_refresh_sequencer.sv
// Port expander refresh sequencer: top level with configuration registers,
// shadow state, sequencer and output register with skid stage.
// Depends on pers_pkg.
//
// Usage: items arrive on the in_ channel (valid/stall). Each item is a
// sequencer tick, a host shadow write, a host shadow read or no operation, and gives
// exactly one result on the out_ channel. A tick may ask the bus master to
// initialise or to start a transfer (address, command, data word, byte
// counts); a host read returns the selected shadow in read_word.
// A result is registered in the output register, or in the skid stage
// while out_stall holds it. Throughput is one item per cycle while in_stall
// is low; the decision is a few flag tests and one 16-bit select between
// the state registers. An output register and a one-entry skid stage part
// the channels, so an item is still taken while one result waits; in_stall
// is high while the skid stage holds a result, which only happens after
// out_stall held the output register. Results are never dropped.
// Reset (rst_n low, synchronous) empties both stages, puts the sequencer in
// the initialise step, clears shadows and marks, and loads the configuration
// registers with their defaults. The user must write configuration over the
// APB-style port while the block is idle (unenforced); pready is always high.
module port_expander_refresh_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pers_pkg::pers_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pers_pkg::pers_out_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pers_pkg::CfgAddrW-1:0]  paddr,
  input  logic [pers_pkg::CfgDataW-1:0]  pwdata,
  output logic [pers_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);

  // configuration registers
  logic [7:0]  device_address_r;
  logic [15:0] default_direction_r;
  logic [15:0] default_polarity_r;
  logic [15:0] default_output_r;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  // shadow state
  logic [pers_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [15:0] direction_shadow_r, direction_shadow_nxt;
  logic [15:0] polarity_shadow_r, polarity_shadow_nxt;
  logic [15:0] output_shadow_r, output_shadow_nxt;
  logic [15:0] input_shadow_r, input_shadow_nxt;
  logic [2:0]  changed_r, changed_nxt;
  logic [2:0]  sent_r, sent_nxt;
  logic        reinit_r, reinit_nxt;
  logic        loaded_r, loaded_nxt;

  // output register and skid stage
  logic                out_vld_r, skid_vld_r;
  pers_pkg::pers_out_t out_r, skid_r;
  pers_pkg::pers_out_t res;

  logic in_acc;
  logic out_fire;
  logic out_load;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r    <= pers_pkg::RST_DEVICE_ADDRESS;
      default_direction_r <= pers_pkg::RST_DEFAULT_DIRECTION;
      default_polarity_r  <= pers_pkg::RST_DEFAULT_POLARITY;
      default_output_r    <= pers_pkg::RST_DEFAULT_OUTPUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pers_pkg::REG_DEVICE_ADDRESS:    device_address_r    <= pwdata[7:0];
        pers_pkg::REG_DEFAULT_DIRECTION: default_direction_r <= pwdata[15:0];
        pers_pkg::REG_DEFAULT_POLARITY:  default_polarity_r  <= pwdata[15:0];
        pers_pkg::REG_DEFAULT_OUTPUT:    default_output_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      pers_pkg::REG_DEVICE_ADDRESS:    prdata = {24'd0, device_address_r};
      pers_pkg::REG_DEFAULT_DIRECTION: prdata = {16'd0, default_direction_r};
      pers_pkg::REG_DEFAULT_POLARITY:  prdata = {16'd0, default_polarity_r};
      pers_pkg::REG_DEFAULT_OUTPUT:    prdata = {16'd0, default_output_r};
      default:                         prdata = '0;
    endcase
  end

  // handshakes
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid & ~in_stall;
  assign out_fire  = out_vld_r & ~out_stall;
  assign out_load  = ~out_vld_r | out_fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // item decision: result and next state
  always_comb begin
    phase_nxt            = phase_r;
    direction_shadow_nxt = direction_shadow_r;
    polarity_shadow_nxt  = polarity_shadow_r;
    output_shadow_nxt    = output_shadow_r;
    input_shadow_nxt     = input_shadow_r;
    changed_nxt          = changed_r;
    sent_nxt             = sent_r;
    reinit_nxt           = reinit_r;
    loaded_nxt           = loaded_r;
    res                  = '0;

    unique case (in_data.opcode)
      pers_pkg::OP_TICK: begin
        unique case (phase_r)
          pers_pkg::PH_INIT: begin
            if (!loaded_r) begin
              direction_shadow_nxt = default_direction_r;
              polarity_shadow_nxt  = default_polarity_r;
              output_shadow_nxt    = default_output_r;
              input_shadow_nxt     = '0;
              loaded_nxt           = 1'b1;
            end
            changed_nxt    = pers_pkg::MARKS_ALL;
            sent_nxt       = '0;
            reinit_nxt     = 1'b0;
            phase_nxt      = pers_pkg::PH_WDIR;
            res.bus_init   = 1'b1;
            res.slot_taken = 1'b1;
          end
          pers_pkg::PH_WDIR: begin
            if (changed_r[pers_pkg::MARK_DIR] && !in_data.bus_busy) begin
              res.start_transfer  = 1'b1;
              res.tx_count        = pers_pkg::TX_COUNT_WRITE;
              res.tx_address_byte = device_address_r;
              res.tx_command      = pers_pkg::CMD_DIRECTION;
              res.tx_word         = direction_shadow_r;
              res.slot_taken      = 1'b1;
              sent_nxt[pers_pkg::MARK_DIR] = 1'b1;
              phase_nxt = pers_pkg::PH_WPOL;
            end
          end
          pers_pkg::PH_WPOL: begin
            if (!in_data.bus_busy) begin
              // retire the direction write
              if (sent_r[pers_pkg::MARK_DIR]) begin
                changed_nxt[pers_pkg::MARK_DIR] = 1'b0;
                sent_nxt[pers_pkg::MARK_DIR]    = 1'b0;
              end
              if (changed_r[pers_pkg::MARK_POL]) begin
                res.start_transfer  = 1'b1;
                res.tx_count        = pers_pkg::TX_COUNT_WRITE;
                res.tx_address_byte = device_address_r;
                res.tx_command      = pers_pkg::CMD_POLARITY;
                res.tx_word         = polarity_shadow_r;
                res.slot_taken      = 1'b1;
                sent_nxt[pers_pkg::MARK_POL] = 1'b1;
              end
              phase_nxt = pers_pkg::PH_WOUT;
            end
          end
          pers_pkg::PH_WOUT: begin
            if (!in_data.bus_busy) begin
              if (sent_r[pers_pkg::MARK_POL]) begin
                changed_nxt[pers_pkg::MARK_POL] = 1'b0;
                sent_nxt[pers_pkg::MARK_POL]    = 1'b0;
              end
              if (changed_r[pers_pkg::MARK_OUT]) begin
                res.start_transfer  = 1'b1;
                res.tx_count        = pers_pkg::TX_COUNT_WRITE;
                res.tx_address_byte = device_address_r;
                res.tx_command      = pers_pkg::CMD_OUTPUT;
                res.tx_word         = output_shadow_r;
                res.slot_taken      = 1'b1;
                sent_nxt[pers_pkg::MARK_OUT] = 1'b1;
              end
              phase_nxt = pers_pkg::PH_RADDR;
            end
          end
          pers_pkg::PH_RADDR: begin
            if (!in_data.bus_busy) begin
              if (sent_r[pers_pkg::MARK_OUT]) begin
                changed_nxt[pers_pkg::MARK_OUT] = 1'b0;
                sent_nxt[pers_pkg::MARK_OUT]    = 1'b0;
              end
              res.start_transfer  = 1'b1;
              res.tx_count        = pers_pkg::TX_COUNT_RADDR;
              res.rx_count        = pers_pkg::RX_COUNT_INPUT;
              res.tx_address_byte = device_address_r;
              res.tx_command      = pers_pkg::CMD_INPUT;
              res.slot_taken      = 1'b1;
              phase_nxt = pers_pkg::PH_RDATA;
            end
          end
          pers_pkg::PH_RDATA: begin
            if (!in_data.bus_busy) begin
              input_shadow_nxt = in_data.received_word;
              phase_nxt      = reinit_r ? pers_pkg::PH_INIT : pers_pkg::PH_WOUT;
              res.slot_taken = 1'b1;
            end
          end
          default: phase_nxt = pers_pkg::PH_INIT;
        endcase
      end
      pers_pkg::OP_HOST_WRITE: begin
        unique case (in_data.reg_select[2:1])
          pers_pkg::SEL_INPUT: begin
            input_shadow_nxt = in_data.write_word;
            reinit_nxt       = 1'b0;
          end
          pers_pkg::SEL_OUTPUT: begin
            // a new output value is always written on the next pass
            output_shadow_nxt            = in_data.write_word;
            changed_nxt[pers_pkg::MARK_OUT] = 1'b1;
            sent_nxt[pers_pkg::MARK_OUT]    = 1'b0;
            reinit_nxt                   = 1'b0;
          end
          pers_pkg::SEL_POLARITY: begin
            polarity_shadow_nxt = in_data.write_word;
            reinit_nxt          = 1'b1;
          end
          pers_pkg::SEL_DIRECTION: begin
            direction_shadow_nxt = in_data.write_word;
            reinit_nxt           = 1'b1;
          end
          default: ;
        endcase
      end
      pers_pkg::OP_HOST_READ: begin
        unique case (in_data.reg_select[2:1])
          pers_pkg::SEL_INPUT:     res.read_word = input_shadow_r;
          pers_pkg::SEL_OUTPUT:    res.read_word = output_shadow_r;
          pers_pkg::SEL_POLARITY:  res.read_word = polarity_shadow_r;
          pers_pkg::SEL_DIRECTION: res.read_word = direction_shadow_r;
          default:                 res.read_word = '0;
        endcase
      end
      pers_pkg::OP_NONE: ;
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= pers_pkg::PH_INIT;
      direction_shadow_r <= '0;
      polarity_shadow_r  <= '0;
      output_shadow_r    <= '0;
      input_shadow_r     <= '0;
      changed_r          <= '0;
      sent_r             <= '0;
      reinit_r           <= 1'b0;
      loaded_r           <= 1'b0;
    end else if (in_acc) begin
      phase_r            <= phase_nxt;
      direction_shadow_r <= direction_shadow_nxt;
      polarity_shadow_r  <= polarity_shadow_nxt;
      output_shadow_r    <= output_shadow_nxt;
      input_shadow_r     <= input_shadow_nxt;
      changed_r          <= changed_nxt;
      sent_r             <= sent_nxt;
      reinit_r           <= reinit_nxt;
      loaded_r           <= loaded_nxt;
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_load) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res;
      end
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  // a result only waits in the skid stage behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a result with the output register empty");

  // a transfer is only marked sent while its write is still pending
  a_sent_within_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (sent_r & ~changed_r) == 3'b000)
    else $error("sent mark set without its change mark");

  // an initialise tick always leads to the direction step with all marks set
  a_init_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.opcode == pers_pkg::OP_TICK && phase_r == pers_pkg::PH_INIT)
    |=> (phase_r == pers_pkg::PH_WDIR && changed_r == pers_pkg::MARKS_ALL
         && sent_r == 3'b000 && loaded_r))
    else $error("initialise step did not set up the write pass");

  // the sequencer never settles in an unused step code
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> phase_r <= pers_pkg::PH_RDATA)
    else $error("sequencer left in an unused step");

endmodule
